### src/vtp_pkg.sv
// ----------------------------------------------------------------------------
// vtp_pkg
// Shared constants, types and helpers for the vertex transform pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package vtp_pkg;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned COORD_WIDTH = 32;
  localparam int unsigned NUM_REGS    = 8;
  localparam int unsigned REG_WIDTH   = 64;
  localparam int unsigned IDX_WIDTH   = 3;
  localparam int unsigned PROD_WIDTH  = 2 * COORD_WIDTH;
  // three floored products plus the translation term
  localparam int unsigned SUM_WIDTH   = PROD_WIDTH - FRAC_BITS + 2;
  localparam int unsigned NUM_WIDTH   = COORD_WIDTH + FRAC_BITS;
  localparam int unsigned FIFO_DEPTH  = 4;

  localparam logic [REG_WIDTH-1:0] MAT_RESET [NUM_REGS] = '{
    64'd4294967296, 64'd0, 64'd281474976710656, 64'd0,
    64'd0, 64'd65536, 64'd0, 64'd281474976710656
  };

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   w_was_zero;
    logic   saturated;
  } result_t;

  // transformed column sums, clamped, waiting for the divide
  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t sz;
    coord_t sw;
    logic   sat;
  } sums_t;

  function automatic coord_t clamp_sum(input logic signed [SUM_WIDTH-1:0] v,
                                       output logic sat);
    logic signed [SUM_WIDTH-1:0] hi;
    logic signed [SUM_WIDTH-1:0] lo;
    hi = SUM_WIDTH'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    lo = -hi - SUM_WIDTH'(1);
    sat = (v > hi) || (v < lo);
    if (v > hi) clamp_sum = coord_t'(hi);
    else if (v < lo) clamp_sum = coord_t'(lo);
    else clamp_sum = coord_t'(v);
  endfunction

endpackage

`default_nettype wire

### src/vtp_if.sv
// ----------------------------------------------------------------------------
// vtp_if
// Valid/ready channel interfaces for points, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface vtp_point_if;
  logic           valid;
  logic           ready;
  vtp_pkg::coord_t x_in;
  vtp_pkg::coord_t y_in;
  vtp_pkg::coord_t z_in;
  modport source (output valid, x_in, y_in, z_in, input ready);
  modport sink   (input valid, x_in, y_in, z_in, output ready);
endinterface

interface vtp_result_if;
  logic           valid;
  logic           ready;
  vtp_pkg::coord_t x_out;
  vtp_pkg::coord_t y_out;
  vtp_pkg::coord_t z_out;
  logic           w_was_zero;
  logic           saturated;
  modport source (output valid, x_out, y_out, z_out, w_was_zero, saturated, input ready);
  modport sink   (input valid, x_out, y_out, z_out, w_was_zero, saturated, output ready);
endinterface

interface vtp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [vtp_pkg::IDX_WIDTH:0]       index;
  logic [vtp_pkg::REG_WIDTH-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### src/vertex_transform_perspective.sv
// ----------------------------------------------------------------------------
// vertex_transform_perspective
// Q16.16 4x4 point transform with perspective divide.
// ----------------------------------------------------------------------------
// Accepts one point per cycle unless stalled by back-pressure, and returns
// one result per point in order. Points pass the multiply's product and sum
// registers, the queue and the divide (one quotient bit per stage over 48
// numerator bits); the multiply and divide are both fully pipelined.
// Register writes are taken at any time and should arrive only while idle.
`default_nettype none

module vertex_transform_perspective (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  vtp_point_if.sink    pt_i,
  vtp_result_if.source res_o,
  vtp_cfg_if.sink      cfg_i
);

  localparam int unsigned CW = vtp_pkg::COORD_WIDTH;

  logic [vtp_pkg::REG_WIDTH-1:0] mat_q [vtp_pkg::NUM_REGS];
  vtp_pkg::coord_t mat [4][4];
  vtp_pkg::point_t pt;
  vtp_pkg::sums_t  f_sums, q_sums;
  vtp_pkg::result_t res;
  logic f_valid, f_ready, q_valid, q_ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < vtp_pkg::NUM_REGS; i++) mat_q[i] <= vtp_pkg::MAT_RESET[i];
    end else if (cfg_i.valid && !cfg_i.index[vtp_pkg::IDX_WIDTH]) begin
      mat_q[cfg_i.index[vtp_pkg::IDX_WIDTH-1:0]] <= cfg_i.data;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      mat[r][0] = mat_q[2*r][CW-1:0];
      mat[r][1] = mat_q[2*r][32+CW-1:32];
      mat[r][2] = mat_q[2*r+1][CW-1:0];
      mat[r][3] = mat_q[2*r+1][32+CW-1:32];
    end
  end

  assign pt.x = pt_i.x_in;
  assign pt.y = pt_i.y_in;
  assign pt.z = pt_i.z_in;

  vtp_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (pt_i.valid), .in_ready_o (pt_i.ready), .in_pt_i (pt),
    .mat_i (mat),
    .out_valid_o (f_valid), .out_ready_i (f_ready), .out_sums_o (f_sums)
  );

  vtp_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i (f_valid), .wr_ready_o (f_ready), .wr_data_i (f_sums),
    .rd_valid_o (q_valid), .rd_ready_i (q_ready), .rd_data_o (q_sums)
  );

  vtp_div u_div (
    .clk_i, .rst_ni,
    .in_valid_i (q_valid), .in_ready_o (q_ready), .in_sums_i (q_sums),
    .out_valid_o (res_o.valid), .out_ready_i (res_o.ready), .out_res_o (res)
  );

  assign res_o.x_out      = res.x;
  assign res_o.y_out      = res.y;
  assign res_o.z_out      = res.z;
  assign res_o.w_was_zero = res.w_was_zero;
  assign res_o.saturated  = res.saturated;

endmodule

`default_nettype wire

### src/vtp_front.sv
// ----------------------------------------------------------------------------
// vtp_front
// Matrix multiply: two stages (products, then floor-sum and clamp) per point.
// ----------------------------------------------------------------------------
`default_nettype none

module vtp_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire vtp_pkg::point_t       in_pt_i,
  input  wire vtp_pkg::coord_t       mat_i [4][4],
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      vtp_pkg::sums_t        out_sums_o
);

  localparam int unsigned PW = vtp_pkg::PROD_WIDTH;
  localparam int unsigned SW = vtp_pkg::SUM_WIDTH;
  localparam int unsigned CW = vtp_pkg::COORD_WIDTH;

  logic v1_q, v2_q;
  logic adv;
  logic signed [PW-1:0] prod_q [3][4];
  logic signed [CW-1:0] trans_q [4];
  vtp_pkg::sums_t       sums_q;
  vtp_pkg::sums_t       sums_d;
  vtp_pkg::coord_t      pin [3];
  logic signed [SW-1:0] acc [4];
  logic                 sat [4];
  vtp_pkg::coord_t      cl [4];

  // whole pipe moves together; output register holds while stalled
  assign adv        = !v2_q || out_ready_i;
  assign in_ready_o = adv;
  assign pin[0] = in_pt_i.x;
  assign pin[1] = in_pt_i.y;
  assign pin[2] = in_pt_i.z;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      acc[c] = SW'(trans_q[c]);
      for (int r = 0; r < 3; r++) begin
        acc[c] = acc[c] + SW'(prod_q[r][c] >>> vtp_pkg::FRAC_BITS);
      end
      cl[c] = vtp_pkg::clamp_sum(acc[c], sat[c]);
    end
    sums_d.sx  = cl[0];
    sums_d.sy  = cl[1];
    sums_d.sz  = cl[2];
    sums_d.sw  = cl[3];
    sums_d.sat = sat[0] | sat[1] | sat[2] | sat[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 3; r++) begin
          prod_q[r][c] <= PW'(pin[r]) * PW'(mat_i[r][c]);
        end
        trans_q[c] <= mat_i[3][c];
      end
      sums_q <= sums_d;
    end
  end

  assign out_valid_o = v2_q;
  assign out_sums_o  = sums_q;

endmodule

`default_nettype wire

### src/vtp_fifo.sv
// ----------------------------------------------------------------------------
// vtp_fifo
// Short queue between the multiply front and the divide back.
// ----------------------------------------------------------------------------
`default_nettype none

module vtp_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_valid_i,
  output      logic           wr_ready_o,
  input  wire vtp_pkg::sums_t wr_data_i,
  output      logic           rd_valid_o,
  input  wire logic           rd_ready_i,
  output      vtp_pkg::sums_t rd_data_o
);

  localparam int unsigned AW = $clog2(vtp_pkg::FIFO_DEPTH);

  vtp_pkg::sums_t mem_q [vtp_pkg::FIFO_DEPTH];
  logic [AW-1:0]  wp_q, rp_q;
  logic [AW:0]    cnt_q;
  logic           wr, rd;

  assign wr_ready_o = cnt_q != (AW+1)'(vtp_pkg::FIFO_DEPTH);
  assign rd_valid_o = cnt_q != '0;
  assign wr         = wr_valid_i && wr_ready_o;
  assign rd         = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + AW'(1);
      if (rd) rp_q <= rp_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

endmodule

`default_nettype wire

### src/vtp_div.sv
// ----------------------------------------------------------------------------
// vtp_div
// Pipelined restoring divider, one quotient bit per stage, for x, y, z by w.
// ----------------------------------------------------------------------------
`default_nettype none

module vtp_div (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output      logic           in_ready_o,
  input  wire vtp_pkg::sums_t in_sums_i,
  output      logic           out_valid_o,
  input  wire logic           out_ready_i,
  output      vtp_pkg::result_t out_res_o
);

  localparam int unsigned NW = vtp_pkg::NUM_WIDTH;
  localparam int unsigned CW = vtp_pkg::COORD_WIDTH;
  localparam int unsigned ST = NW;

  typedef struct packed {
    logic [2:0][NW-1:0] quo;
    logic [2:0][CW-1:0] rem;
    logic [2:0][NW-1:0] num;
    logic [2:0]         neg;
    logic [2:0][CW-1:0] raw;
    logic [CW-1:0]      den;
    logic               wz;
    logic               sat;
  } lane_t;

  logic  vld_q [ST+1];
  lane_t ln_q  [ST+1];
  lane_t ln_d  [ST+1];
  logic  adv;
  vtp_pkg::coord_t sv [3];
  vtp_pkg::result_t res_d;

  assign adv        = !vld_q[ST] || out_ready_i;
  assign in_ready_o = adv;
  assign sv[0] = in_sums_i.sx;
  assign sv[1] = in_sums_i.sy;
  assign sv[2] = in_sums_i.sz;

  // stage 0 takes magnitudes; stages 1..ST each retire one quotient bit
  always_comb begin
    logic signed [CW-1:0] w;
    logic [CW:0]          trial;
    w = in_sums_i.sw;
    ln_d[0] = '0;
    ln_d[0].den = w[CW-1] ? CW'(-w) : CW'(w);
    ln_d[0].wz  = (w == '0);
    ln_d[0].sat = in_sums_i.sat;
    for (int k = 0; k < 3; k++) begin
      ln_d[0].raw[k] = sv[k];
      ln_d[0].neg[k] = sv[k][CW-1] ^ w[CW-1];
      ln_d[0].num[k] = {(sv[k][CW-1] ? CW'(-sv[k]) : CW'(sv[k])),
                        {vtp_pkg::FRAC_BITS{1'b0}}};
    end
    for (int s = 1; s <= ST; s++) begin
      ln_d[s] = ln_q[s-1];
      for (int k = 0; k < 3; k++) begin
        trial = {ln_q[s-1].rem[k], ln_q[s-1].num[k][NW-1]};
        ln_d[s].num[k] = {ln_q[s-1].num[k][NW-2:0], 1'b0};
        if (trial >= {1'b0, ln_q[s-1].den}) begin
          ln_d[s].rem[k] = CW'(trial - {1'b0, ln_q[s-1].den});
          ln_d[s].quo[k] = {ln_q[s-1].quo[k][NW-2:0], 1'b1};
        end else begin
          ln_d[s].rem[k] = CW'(trial);
          ln_d[s].quo[k] = {ln_q[s-1].quo[k][NW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= ST; s++) vld_q[s] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
      for (int s = 1; s <= ST; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int s = 0; s <= ST; s++) ln_q[s] <= ln_d[s];
    end
  end

  // sign fix and clamp of the magnitude quotient; raw sums pass when w is zero
  always_comb begin
    logic [NW:0]  mag;
    logic         ov;
    logic         satq;
    vtp_pkg::coord_t q [3];
    satq = 1'b0;
    for (int k = 0; k < 3; k++) begin
      mag = {1'b0, ln_q[ST].quo[k]};
      if (ln_q[ST].neg[k]) begin
        ov   = mag > (NW+1)'({1'b1, {(CW-1){1'b0}}});
        q[k] = ov ? {1'b1, {(CW-1){1'b0}}} : CW'(-mag);
      end else begin
        ov   = mag > (NW+1)'({1'b0, {(CW-1){1'b1}}});
        q[k] = ov ? {1'b0, {(CW-1){1'b1}}} : CW'(mag);
      end
      if (ln_q[ST].wz) q[k] = ln_q[ST].raw[k];
      else satq = satq | ov;
    end
    res_d.x = q[0];
    res_d.y = q[1];
    res_d.z = q[2];
    res_d.w_was_zero = ln_q[ST].wz;
    res_d.saturated  = ln_q[ST].sat | satq;
  end

  assign out_valid_o = vld_q[ST];
  assign out_res_o   = res_d;

endmodule

`default_nettype wire

### bench/vertex_transform_perspective_tb.sv
// ----------------------------------------------------------------------------
// vertex_transform_perspective_tb
// Drives points through the 4x4 transform under several matrix settings with
// random gaps on both channels; every result is checked against a local
// fixed-point model of the transform and perspective divide.
// ----------------------------------------------------------------------------
module vertex_transform_perspective_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LATENCY = 60;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  vtp_point_if  pt_bus ();
  vtp_result_if res_bus ();
  vtp_cfg_if    cfg_bus ();

  vertex_transform_perspective DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pt_i  (pt_bus.sink),
    .res_o (res_bus.source),
    .cfg_i (cfg_bus.sink)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  typedef struct {
    vtp_pkg::coord_t  x;
    vtp_pkg::coord_t  y;
    vtp_pkg::coord_t  z;
    logic             known;
    vtp_pkg::result_t want;
  } stim_row_t;

  logic [vtp_pkg::REG_WIDTH-1:0] matrix_regs [vtp_pkg::NUM_REGS];
  vtp_pkg::result_t              pending_results [$];
  int                            mismatch_count = 0;
  bit                            failed = 0;
  bit                            drain_ready = 0;

  function automatic longint mat_entry(int row, int col);
    logic [vtp_pkg::REG_WIDTH-1:0] r;
    r = matrix_regs[row * 2 + col / 2];
    return longint'(vtp_pkg::coord_t'((col % 2) ? r[63:32] : r[31:0]));
  endfunction

  function automatic longint clamp_coord(longint v, ref bit sat);
    longint hi;
    longint lo;
    hi = 64'sd2147483647;
    lo = -hi - 1;
    if (v > hi) begin
      sat = 1;
      return hi;
    end
    if (v < lo) begin
      sat = 1;
      return lo;
    end
    return v;
  endfunction

  function automatic vtp_pkg::result_t transform_point(vtp_pkg::coord_t x, vtp_pkg::coord_t y,
                                                       vtp_pkg::coord_t z);
    longint           p [3];
    longint           s [4];
    longint           prod;
    bit               sat;
    vtp_pkg::result_t r;
    sat = 0;
    p[0] = x; p[1] = y; p[2] = z;
    for (int c = 0; c < 4; c++) begin
      s[c] = mat_entry(3, c);
      for (int k = 0; k < 3; k++) begin
        prod = p[k] * mat_entry(k, c);
        s[c] += prod >>> vtp_pkg::FRAC_BITS;  // floor toward minus infinity
      end
      s[c] = clamp_coord(s[c], sat);
    end
    r.w_was_zero = (s[3] == 0);
    if (s[3] != 0)
      for (int c = 0; c < 3; c++)
        s[c] = clamp_coord((s[c] * 65536) / s[3], sat);
    r.x = vtp_pkg::coord_t'(s[0]);
    r.y = vtp_pkg::coord_t'(s[1]);
    r.z = vtp_pkg::coord_t'(s[2]);
    r.saturated = sat;
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(5, 30);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  function automatic vtp_pkg::coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return vtp_pkg::coord_t'($urandom);
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      default: return vtp_pkg::coord_t'($signed($urandom_range(0, 32'h000fffff))
                                         - 32'sh00080000);
    endcase
  endfunction

  task automatic write_reg(int idx, logic [vtp_pkg::REG_WIDTH-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx[vtp_pkg::IDX_WIDTH:0];
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    if (idx < vtp_pkg::NUM_REGS) matrix_regs[idx] = value;
    @(posedge clk_i);
  endtask

  task automatic send_point(vtp_pkg::coord_t x, vtp_pkg::coord_t y, vtp_pkg::coord_t z,
                            logic known, vtp_pkg::result_t want);
    vtp_pkg::result_t predicted;
    int               gap;
    predicted = transform_point(x, y, z);
    if (known && predicted !== want) begin
      failed = 1;
      $display("table row disagrees with model: %h vs %h", want, predicted);
    end
    pt_bus.valid <= 1'b1;
    pt_bus.x_in  <= x;
    pt_bus.y_in  <= y;
    pt_bus.z_in  <= z;
    do @(posedge clk_i); while (!pt_bus.ready);
    pending_results.push_back(predicted);
    gap = gap_len();
    if (gap > 0) begin
      pt_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_and_settle();
    pt_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  // result side: random stalls, compare every transaction with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_bus.valid && res_bus.ready) begin
        vtp_pkg::result_t got;
        vtp_pkg::result_t want;
        got = '{res_bus.x_out, res_bus.y_out, res_bus.z_out,
                res_bus.w_was_zero, res_bus.saturated};
        if (pending_results.size() == 0) begin
          failed = 1;
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result %h", got);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            failed = 1;
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: x %h/%h y %h/%h z %h/%h wz %b/%b sat %b/%b",
                       want.x, got.x, want.y, got.y, want.z, got.z,
                       want.w_was_zero, got.w_was_zero, want.saturated, got.saturated);
          end
        end
      end
      res_bus.ready <= drain_ready ? 1'b1 : ($urandom_range(0, 19) == 0 ? 1'b0 :
                       ($urandom_range(0, 3) != 0));
    end
  end

  initial begin
    stim_row_t rows [$];
    int        phase_count;
    pt_bus.valid  = 1'b0;
    pt_bus.x_in   = '0;
    pt_bus.y_in   = '0;
    pt_bus.z_in   = '0;
    res_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data  = '0;
    for (int i = 0; i < vtp_pkg::NUM_REGS; i++) matrix_regs[i] = vtp_pkg::MAT_RESET[i];
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset matrix: x scaled by a raw unit lands in y, w is one
    rows.push_back('{32'sh00010000, 32'sh00020000, 32'sh00030000, 1'b1,
                     '{32'sh0, 32'sh00020001, 32'sh00030000, 1'b0, 1'b0}});
    rows.push_back('{32'sh0, 32'sh0, 32'sh0, 1'b1, '{32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b0}});
    rows.push_back('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0, '0});
    rows.push_back('{32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0, '0});
    rows.push_back('{32'shffffffff, 32'sh00000001, 32'shffff0000, 1'b0, '0});
    foreach (rows[i]) send_point(rows[i].x, rows[i].y, rows[i].z, rows[i].known, rows[i].want);
    drain_and_settle();

    // w column zero: no divide, flag raised
    write_reg(7, 64'h0);
    write_reg(8, 64'hffffffffffffffff);  // out-of-range index is ignored
    send_point(32'sh00010000, 32'sh00020000, 32'sh00030000, 1'b1,
               '{32'sh0, 32'sh00020001, 32'sh00030000, 1'b1, 1'b0});
    send_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0, '0);
    drain_and_settle();

    // extremes: all entries max, then min
    for (int i = 0; i < vtp_pkg::NUM_REGS; i++) write_reg(i, 64'h7fffffff7fffffff);
    send_point(32'sh7fffffff, 32'sh80000000, 32'sh00010000, 1'b0, '0);
    send_point(32'sh00000001, 32'sh0, 32'sh0, 1'b0, '0);
    drain_and_settle();
    for (int i = 0; i < vtp_pkg::NUM_REGS; i++) write_reg(i, 64'h8000000080000000);
    send_point(32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0, '0);
    send_point(32'shffffffff, 32'sh00000001, 32'sh0, 1'b0, '0);
    drain_and_settle();

    // random phases with new matrices, w often small so the divide does work
    phase_count = 8;
    for (int ph = 0; ph < phase_count; ph++) begin
      for (int i = 0; i < vtp_pkg::NUM_REGS; i++) begin
        logic [vtp_pkg::REG_WIDTH-1:0] v;
        v = {$urandom, $urandom};
        if (ph % 2 == 0) v = {32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000),
                              32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000)};
        if (i == 7 && ph == 3) v[63:32] = 32'h0;
        write_reg(i, v);
      end
      for (int n = 0; n < 118; n++) send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0, '0);
      drain_and_settle();
    end

    drain_ready = 1;
    repeat (LATENCY) @(posedge clk_i);
    if (!failed && pending_results.size() == 0) begin
      $display("vertex_transform_perspective_tb OK");
    end else begin
      $display("vertex_transform_perspective_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("vertex_transform_perspective_tb NOT OK");
    $finish;
  end
endmodule
